/* design/mpap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpap_pkg
// Shared widths, constants, tables and payload types of the quadratic phase
// mask pixel pipeline.
// ---------------------------------------------------------------------------
package mpap_pkg;

  localparam int MAX_GRID     = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int IDX_W        = 10;
  localparam int GRID_W       = 11;
  localparam int APER_W       = 22;
  localparam int PHASE_W      = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;

  localparam int GUARD        = 32 - SAMPLE_BITS;
  localparam int UW           = IDX_W + 3;
  localparam int SQW          = 2 * (IDX_W + 1);
  localparam int SW           = SQW + 1;
  localparam int XW           = SAMPLE_BITS + GUARD + 3;
  localparam int ZW           = 32;
  localparam int CORDIC_STEPS = 16;

  localparam int LO_W         = 17;
  localparam int HI_W         = XW - LO_W;
  localparam int GAIN_W       = 30;
  localparam int PW           = HI_W + GAIN_W + 1 + LO_W;
  localparam int RSH          = GUARD + 30;
  localparam int RW           = PW - RSH;

  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);
  localparam logic [PW-1:0]     ROUND_BIAS   = {{(PW-1){1'b0}}, 1'b1} << (GUARD + 29);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 2'd2;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  localparam logic [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 clip;
  } rot_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 clip;
  } vec_t;

endpackage
`default_nettype wire

/* design/mirror_phase_aperture_pixel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mirror_phase_aperture_pixel
// Quadratic phase mask with circular aperture, one complex pixel per beat.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one grid sample per beat (row, column, Q1.15 re/im).
//   out_*  : rotated Q1.15 sample, or zero with out_clipped set when the
//            index lies outside the grid or outside the aperture.
//   cfg_*  : register writes; index 0 grid_size, 1 aperture_limit,
//            2 phase_step, other indexes ignored. cfg_ready is always high.
//            Write only while the pipeline is empty.
// Pipeline: 5 front stages, 16 CORDIC stages, 2 gain/round stages.
// Throughput: one beat per cycle while the output is not stalled; every stage is a full register stage.
// Stall: each stage holds while its successor is full and stalled, so
//   bubbles collapse and in_ready drops only once all 23 stages are full.
// Reset: pipeline empty; grid_size 1024, aperture_limit 4194303,
//   phase_step 0.
// ---------------------------------------------------------------------------
module mirror_phase_aperture_pixel (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [mpap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mpap_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [mpap_pkg::IDX_W-1:0]              in_row_index,
  input  wire logic [mpap_pkg::IDX_W-1:0]              in_col_index,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] in_sample_re,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] in_sample_im,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [mpap_pkg::SAMPLE_BITS-1:0]      out_result_re,
  output logic signed [mpap_pkg::SAMPLE_BITS-1:0]      out_result_im,
  output logic                                         out_clipped
);

  logic [mpap_pkg::GRID_W-1:0]  grid_size_r;
  logic [mpap_pkg::APER_W-1:0]  aperture_limit_r;
  logic [mpap_pkg::PHASE_W-1:0] phase_step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r      <= mpap_pkg::GRID_W'(1024);
      aperture_limit_r <= mpap_pkg::APER_W'(4194303);
      phase_step_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpap_pkg::REG_GRID_SIZE:      grid_size_r      <= cfg_data[mpap_pkg::GRID_W-1:0];
        mpap_pkg::REG_APERTURE_LIMIT: aperture_limit_r <= cfg_data[mpap_pkg::APER_W-1:0];
        mpap_pkg::REG_PHASE_STEP:     phase_step_r     <= cfg_data[mpap_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  logic           f_valid, f_ready;
  mpap_pkg::rot_t f_data;
  logic           c_valid, c_ready;
  mpap_pkg::vec_t c_data;

  mpap_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .grid_size      (grid_size_r),
    .aperture_limit (aperture_limit_r),
    .phase_step     (phase_step_r),
    .up_valid       (in_valid),
    .up_ready       (in_ready),
    .row_index      (in_row_index),
    .col_index      (in_col_index),
    .sample_re      (in_sample_re),
    .sample_im      (in_sample_im),
    .dn_valid       (f_valid),
    .dn_ready       (f_ready),
    .dn_data        (f_data)
  );

  mpap_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  mpap_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (c_valid),
    .up_ready  (c_ready),
    .up_data   (c_data),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .result_re (out_result_re),
    .result_im (out_result_im),
    .clipped   (out_clipped)
  );

endmodule
`default_nettype wire

/* design/mpap_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpap_front
// Five stages: centered coordinates, squares, aperture test, phase product,
// quadrant fold and residual angle.
// ---------------------------------------------------------------------------
module mpap_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [mpap_pkg::GRID_W-1:0]         grid_size,
  input  wire logic [mpap_pkg::APER_W-1:0]         aperture_limit,
  input  wire logic [mpap_pkg::PHASE_W-1:0]        phase_step,
  input  wire logic                                up_valid,
  output logic                                     up_ready,
  input  wire logic [mpap_pkg::IDX_W-1:0]          row_index,
  input  wire logic [mpap_pkg::IDX_W-1:0]          col_index,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] sample_re,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] sample_im,
  output logic                                     dn_valid,
  input  wire logic                                dn_ready,
  output mpap_pkg::rot_t                           dn_data
);

  localparam int NST = 5;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  assign en[NST-1] = !v_r[NST-1] || dn_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: coordinates
  logic [mpap_pkg::GRID_W-1:0]             n_eff;
  logic signed [mpap_pkg::UW-1:0]          u_nxt, v_nxt, u_r, v_r1;
  logic                                    out1_nxt, out1_r;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] re1_r, im1_r;

  always_comb begin
    n_eff = (grid_size > mpap_pkg::GRID_W'(mpap_pkg::MAX_GRID))
          ? mpap_pkg::GRID_W'(mpap_pkg::MAX_GRID) : grid_size;
    u_nxt = $signed({2'b00, row_index, 1'b0}) - $signed({2'b00, n_eff})
          + $signed(mpap_pkg::UW'(1));
    v_nxt = $signed({2'b00, col_index, 1'b0}) - $signed({2'b00, n_eff})
          + $signed(mpap_pkg::UW'(1));
    out1_nxt = ({1'b0, row_index} >= n_eff) || ({1'b0, col_index} >= n_eff);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r    <= u_nxt;
      v_r1   <= v_nxt;
      out1_r <= out1_nxt;
      re1_r  <= sample_re;
      im1_r  <= sample_im;
    end
  end

  // stage 2: squares
  logic signed [2*mpap_pkg::UW-1:0]        uu_full, vv_full;
  logic [mpap_pkg::SQW-1:0]                uu_r, vv_r;
  logic                                    out2_r;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] re2_r, im2_r;

  assign uu_full = u_r * u_r;
  assign vv_full = v_r1 * v_r1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      uu_r   <= uu_full[mpap_pkg::SQW-1:0];
      vv_r   <= vv_full[mpap_pkg::SQW-1:0];
      out2_r <= out1_r;
      re2_r  <= re1_r;
      im2_r  <= im1_r;
    end
  end

  // stage 3: radius and aperture
  logic [mpap_pkg::SW-1:0]                 s_nxt, s_r;
  logic                                    clip3_r;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] re3_r, im3_r;

  assign s_nxt = {1'b0, uu_r} + {1'b0, vv_r};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s_r     <= s_nxt;
      clip3_r <= out2_r || (s_nxt > mpap_pkg::SW'(aperture_limit));
      re3_r   <= re2_r;
      im3_r   <= im2_r;
    end
  end

  // stage 4: phase product, mod one turn
  logic [mpap_pkg::SW+mpap_pkg::PHASE_W-1:0] prod_full;
  logic [mpap_pkg::ZW-1:0]                   prod_r;
  logic                                      clip4_r;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0]   re4_r, im4_r;

  assign prod_full = s_r * phase_step;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      prod_r  <= prod_full[mpap_pkg::ZW-1:0];
      clip4_r <= clip3_r;
      re4_r   <= re3_r;
      im4_r   <= im3_r;
    end
  end

  // stage 5: quadrant fold
  logic [mpap_pkg::ZW-1:0]         ang, ang_half;
  logic [1:0]                      quad;
  logic signed [mpap_pkg::XW-1:0]  re_ext, im_ext;
  mpap_pkg::rot_t                  rot_nxt, rot_r;

  always_comb begin
    ang      = mpap_pkg::ZW'(0) - prod_r;
    ang_half = ang + 32'h2000_0000;
    quad     = ang_half[mpap_pkg::ZW-1:mpap_pkg::ZW-2];
    re_ext   = {{(mpap_pkg::XW-mpap_pkg::SAMPLE_BITS-mpap_pkg::GUARD){re4_r[mpap_pkg::SAMPLE_BITS-1]}},
                re4_r, {mpap_pkg::GUARD{1'b0}}};
    im_ext   = {{(mpap_pkg::XW-mpap_pkg::SAMPLE_BITS-mpap_pkg::GUARD){im4_r[mpap_pkg::SAMPLE_BITS-1]}},
                im4_r, {mpap_pkg::GUARD{1'b0}}};
    rot_nxt.z    = $signed(ang - {quad, {(mpap_pkg::ZW-2){1'b0}}});
    rot_nxt.clip = clip4_r;
    case (quad)
      mpap_pkg::QUAD_90: begin
        rot_nxt.x = -im_ext;
        rot_nxt.y = re_ext;
      end
      mpap_pkg::QUAD_180: begin
        rot_nxt.x = -re_ext;
        rot_nxt.y = -im_ext;
      end
      mpap_pkg::QUAD_270: begin
        rot_nxt.x = im_ext;
        rot_nxt.y = -re_ext;
      end
      default: begin
        rot_nxt.x = re_ext;
        rot_nxt.y = im_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) rot_r <= rot_nxt;
  end

  assign dn_data = rot_r;

endmodule
`default_nettype wire

/* design/mpap_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpap_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// ---------------------------------------------------------------------------
module mpap_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire mpap_pkg::rot_t  up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output mpap_pkg::vec_t       dn_data
);

  localparam int NST = mpap_pkg::CORDIC_STEPS;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic signed [mpap_pkg::XW-1:0] x_r [NST];
  logic signed [mpap_pkg::XW-1:0] y_r [NST];
  logic signed [mpap_pkg::ZW-1:0] z_r [NST];
  logic                           c_r [NST];

  assign en[NST-1] = !v_r[NST-1] || dn_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic signed [mpap_pkg::XW-1:0] xi, yi, dx, dy;
    logic signed [mpap_pkg::ZW-1:0] zi;
    logic                           ci;

    if (k == 0) begin : g_first
      assign xi = up_data.x;
      assign yi = up_data.y;
      assign zi = up_data.z;
      assign ci = up_data.clip;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign ci = c_r[k-1];
    end

    assign dx = yi >>> k;
    assign dy = xi >>> k;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (!zi[mpap_pkg::ZW-1]) begin
          x_r[k] <= xi - dx;
          y_r[k] <= yi + dy;
          z_r[k] <= zi - $signed(mpap_pkg::ATAN_TURNS[k]);
        end else begin
          x_r[k] <= xi + dx;
          y_r[k] <= yi - dy;
          z_r[k] <= zi + $signed(mpap_pkg::ATAN_TURNS[k]);
        end
        c_r[k] <= ci;
      end
    end
  end

  assign dn_data.x    = x_r[NST-1];
  assign dn_data.y    = y_r[NST-1];
  assign dn_data.clip = c_r[NST-1];

endmodule
`default_nettype wire

/* design/mpap_scale.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpap_scale
// Gain correction in split partial products, round half up, saturate to
// Q1.15, zero clipped samples. Second stage is the output register.
// ---------------------------------------------------------------------------
module mpap_scale (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                up_valid,
  output logic                                     up_ready,
  input  wire mpap_pkg::vec_t                      up_data,
  output logic                                     dn_valid,
  input  wire logic                                dn_ready,
  output logic signed [mpap_pkg::SAMPLE_BITS-1:0]  result_re,
  output logic signed [mpap_pkg::SAMPLE_BITS-1:0]  result_im,
  output logic                                     clipped
);

  localparam int HPW = mpap_pkg::HI_W + mpap_pkg::GAIN_W + 1;
  localparam int LPW = mpap_pkg::LO_W + mpap_pkg::GAIN_W;

  function automatic logic signed [mpap_pkg::SAMPLE_BITS-1:0] finish(
    input logic signed [HPW-1:0] ph,
    input logic        [LPW-1:0] pl
  );
    logic signed [mpap_pkg::PW-1:0] p;
    logic signed [mpap_pkg::RW-1:0] r;
    logic [mpap_pkg::RW-mpap_pkg::SAMPLE_BITS:0] top;
    p   = $signed({ph, {mpap_pkg::LO_W{1'b0}}})
        + $signed({{(mpap_pkg::PW-LPW){1'b0}}, pl})
        + $signed(mpap_pkg::ROUND_BIAS);
    r   = p[mpap_pkg::PW-1:mpap_pkg::RSH];
    top = r[mpap_pkg::RW-1:mpap_pkg::SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      finish = r[mpap_pkg::SAMPLE_BITS-1:0];
    end else if (r[mpap_pkg::RW-1]) begin
      finish = {1'b1, {(mpap_pkg::SAMPLE_BITS-1){1'b0}}};
    end else begin
      finish = {1'b0, {(mpap_pkg::SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  logic [1:0] v_r;
  logic [1:0] en;

  assign en[1]    = !v_r[1] || dn_ready;
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  // stage 1: partial products
  logic signed [HPW-1:0] xph_r, yph_r;
  logic        [LPW-1:0] xpl_r, ypl_r;
  logic                  clip1_r;
  logic signed [mpap_pkg::GAIN_W:0] gain_s;

  assign gain_s = $signed({1'b0, mpap_pkg::INV_GAIN_Q30});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xph_r   <= $signed(up_data.x[mpap_pkg::XW-1:mpap_pkg::LO_W]) * gain_s;
      yph_r   <= $signed(up_data.y[mpap_pkg::XW-1:mpap_pkg::LO_W]) * gain_s;
      xpl_r   <= up_data.x[mpap_pkg::LO_W-1:0] * mpap_pkg::INV_GAIN_Q30;
      ypl_r   <= up_data.y[mpap_pkg::LO_W-1:0] * mpap_pkg::INV_GAIN_Q30;
      clip1_r <= up_data.clip;
    end
  end

  // stage 2: sum, round, saturate
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] re_r, im_r;
  logic                                    clip2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      re_r    <= clip1_r ? '0 : finish(xph_r, xpl_r);
      im_r    <= clip1_r ? '0 : finish(yph_r, ypl_r);
      clip2_r <= clip1_r;
    end
  end

  assign result_re = re_r;
  assign result_im = im_r;
  assign clipped   = clip2_r;

endmodule
`default_nettype wire

/* design/mpap_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpap_checker
// Port-level checks of the phase mask pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module mpap_checker (
  input wire logic                                    clk,
  input wire logic                                    rst_n,
  input wire logic                                    in_ready,
  input wire logic                                    out_valid,
  input wire logic                                    out_ready,
  input wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] out_result_re,
  input wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] out_result_im,
  input wire logic                                    out_clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_re) && $stable(out_result_im)
                                && $stable(out_clipped))
    else $error("output beat changed while stalled");

  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_result_re == 0 && out_result_im == 0)
    else $error("clipped beat not zero");

  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind mirror_phase_aperture_pixel mpap_checker u_mpap_checker (.*);
`default_nettype wire

/* test/mpap_pixel_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpap_pixel_checker
// Watches the register, sample and result channels of the phase mask pixel
// pipeline, predicts each masked and rotated pixel at acceptance and compares
// results in order against the queue of predicted pixels.
// ---------------------------------------------------------------------------
module mpap_pixel_checker (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_valid,
  input  wire logic                                    cfg_ready,
  input  wire logic [mpap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mpap_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                    in_valid,
  input  wire logic                                    in_ready,
  input  wire logic [mpap_pkg::IDX_W-1:0]              in_row_index,
  input  wire logic [mpap_pkg::IDX_W-1:0]              in_col_index,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] in_sample_re,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] in_sample_im,
  input  wire logic                                    out_valid,
  input  wire logic                                    out_ready,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] out_result_re,
  input  wire logic signed [mpap_pkg::SAMPLE_BITS-1:0] out_result_im,
  input  wire logic                                    out_clipped,
  output int                                           mismatches,
  output int                                           pending
);

  typedef struct packed {
    logic signed [mpap_pkg::SAMPLE_BITS-1:0] re;
    logic signed [mpap_pkg::SAMPLE_BITS-1:0] im;
    logic                                    clipped;
  } pixel_t;

  logic [mpap_pkg::GRID_W-1:0]  grid_q;
  logic [mpap_pkg::APER_W-1:0]  aper_q;
  logic [mpap_pkg::PHASE_W-1:0] step_q;
  pixel_t                       pixel_q[$];
  int                           beat_no;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch beat %0d: %s", beat_no, what);
    mismatches++;
  endtask

  // gain correction, round half up, saturate
  function automatic logic signed [mpap_pkg::SAMPLE_BITS-1:0] gain_round_sat(
    input longint w
  );
    longint p;
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (mpap_pkg::SAMPLE_BITS - 1)) - 1;
    lo = -(longint'(1) <<< (mpap_pkg::SAMPLE_BITS - 1));
    p  = w * longint'(mpap_pkg::INV_GAIN_Q30) + (longint'(1) <<< (mpap_pkg::GUARD + 29));
    r  = p >>> (mpap_pkg::GUARD + 30);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return mpap_pkg::SAMPLE_BITS'(r);
  endfunction

  function automatic pixel_t mask_rotate_pixel(
    input logic [mpap_pkg::IDX_W-1:0]              row,
    input logic [mpap_pkg::IDX_W-1:0]              col,
    input logic signed [mpap_pkg::SAMPLE_BITS-1:0] re,
    input logic signed [mpap_pkg::SAMPLE_BITS-1:0] im
  );
    longint      n, r_i, c_i, u, v, s, x, y, zz, t, dx, dy, re_l, im_l;
    logic [63:0] prod;
    logic [31:0] ang, rem;
    logic [1:0]  quad;
    pixel_t      res;
    n   = grid_q;
    r_i = row;
    c_i = col;
    if (n > mpap_pkg::MAX_GRID) n = mpap_pkg::MAX_GRID;
    u = 2 * r_i - (n - 1);
    v = 2 * c_i - (n - 1);
    s = u * u + v * v;
    if (r_i >= n || c_i >= n || s > longint'(aper_q)) begin
      res = '{re: '0, im: '0, clipped: 1'b1};
      return res;
    end
    prod = 64'(s) * {32'd0, step_q};
    ang  = 32'd0 - prod[31:0];
    quad = 2'((ang + 32'h2000_0000) >> 30);
    rem  = ang - {quad, 30'd0};
    zz   = $signed(rem);
    re_l = longint'(re) * (longint'(1) <<< mpap_pkg::GUARD);
    im_l = longint'(im) * (longint'(1) <<< mpap_pkg::GUARD);
    case (quad)
      mpap_pkg::QUAD_90: begin
        x = -im_l; y = re_l;
      end
      mpap_pkg::QUAD_180: begin
        x = -re_l; y = -im_l;
      end
      mpap_pkg::QUAD_270: begin
        x = im_l; y = -re_l;
      end
      default: begin
        x = re_l; y = im_l;
      end
    endcase
    for (int i = 0; i < mpap_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (zz >= 0) begin
        t = x - dx; y = y + dy; x = t;
        zz -= longint'(mpap_pkg::ATAN_TURNS[i]);
      end else begin
        t = x + dx; y = y - dy; x = t;
        zz += longint'(mpap_pkg::ATAN_TURNS[i]);
      end
    end
    res.re      = gain_round_sat(x);
    res.im      = gain_round_sat(y);
    res.clipped = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      grid_q     = 11'd1024;
      aper_q     = 22'd4194303;
      step_q     = '0;
      mismatches = 0;
      beat_no    = 0;
      pixel_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = pixel_q.pop_front();
          if (out_result_re !== want.re)
            report_mismatch($sformatf("result_re got %0d want %0d", out_result_re, want.re));
          if (out_result_im !== want.im)
            report_mismatch($sformatf("result_im got %0d want %0d", out_result_im, want.im));
          if (out_clipped !== want.clipped)
            report_mismatch($sformatf("clipped got %b want %b", out_clipped, want.clipped));
        end
        beat_no++;
      end
      if (in_valid && in_ready)
        pixel_q.push_back(mask_rotate_pixel(in_row_index, in_col_index,
                                            in_sample_re, in_sample_im));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mpap_pkg::REG_GRID_SIZE:      grid_q = cfg_data[mpap_pkg::GRID_W-1:0];
          mpap_pkg::REG_APERTURE_LIMIT: aper_q = cfg_data[mpap_pkg::APER_W-1:0];
          mpap_pkg::REG_PHASE_STEP:     step_q = cfg_data[mpap_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end
      pending <= pixel_q.size();
    end
  end

endmodule

/* test/mirror_phase_aperture_pixel_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mirror_phase_aperture_pixel_tb
// Drives register settings and grid samples into the phase mask pipeline:
// a directed set of corners, quadrants, grid and aperture edges, then random
// phases under varied source gaps and sink stalls, including one long sink
// hold-off that backs up the pipeline. A checker predicts and compares.
// ---------------------------------------------------------------------------
module mirror_phase_aperture_pixel_tb;

  localparam logic [mpap_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 66;

  logic                                    clk = 1'b0;
  logic                                    rst_n = 1'b0;
  logic                                    cfg_valid = 1'b0;
  logic                                    cfg_ready;
  logic [mpap_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
  logic [mpap_pkg::CFG_DATA_W-1:0]         cfg_data = '0;
  logic                                    in_valid = 1'b0;
  logic                                    in_ready;
  logic [mpap_pkg::IDX_W-1:0]              in_row_index = '0;
  logic [mpap_pkg::IDX_W-1:0]              in_col_index = '0;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] in_sample_re = '0;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] in_sample_im = '0;
  logic                                    out_valid;
  logic                                    out_ready = 1'b0;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] out_result_re;
  logic signed [mpap_pkg::SAMPLE_BITS-1:0] out_result_im;
  logic                                    out_clipped;

  int mismatches;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  mirror_phase_aperture_pixel u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_re (out_result_re),
    .out_result_im (out_result_im),
    .out_clipped   (out_clipped)
  );

  mpap_pixel_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_re (out_result_re),
    .out_result_im (out_result_im),
    .out_clipped   (out_clipped),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // sink: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holds_served != hold_reqs) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("[mirror_phase_aperture_pixel] ERROR");
      $finish;
    end
  end

  task automatic send_pixel(input logic [mpap_pkg::IDX_W-1:0] row,
                            input logic [mpap_pkg::IDX_W-1:0] col,
                            input logic signed [mpap_pkg::SAMPLE_BITS-1:0] re,
                            input logic signed [mpap_pkg::SAMPLE_BITS-1:0] im);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_row_index <= row;
    in_col_index <= col;
    in_sample_re <= re;
    in_sample_im <= im;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // writes all registers plus the unused index, pipeline empty
  task automatic apply_config(input logic [31:0] grid, input logic [31:0] aper,
                              input logic [31:0] step);
    logic [mpap_pkg::CFG_IDX_W-1:0] idx [4];
    logic [31:0]                    dat [4];
    idx = '{mpap_pkg::REG_GRID_SIZE, mpap_pkg::REG_APERTURE_LIMIT,
            mpap_pkg::REG_PHASE_STEP, REG_SPARE};
    dat = '{grid, aper, step, $urandom};
    wait_drain();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [mpap_pkg::SAMPLE_BITS-1:0] rand_sample();
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    return mpap_pkg::SAMPLE_BITS'($urandom);
  endfunction

  initial begin
    int unsigned g, gm, span, aper;
    logic [31:0] step;
    logic [mpap_pkg::IDX_W-1:0] row, col;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full grid, open aperture, flat phase
    send_pixel(10'd0, 10'd0, -16'sd32768, -16'sd32768);
    send_pixel(10'd1023, 10'd1023, 16'sd32767, 16'sd32767);
    send_pixel(10'd0, 10'd1023, 16'sd32767, -16'sd32768);
    send_pixel(10'd511, 10'd512, 16'sd0, 16'sd0);
    send_pixel(10'd512, 10'd511, -16'sd1, 16'sd1);
    // 2x2 grid, one quadrant per setting
    apply_config(32'd2, 32'd2, 32'h2000_0000);
    send_pixel(10'd0, 10'd0, 16'sd32767, -16'sd32768);
    send_pixel(10'd1, 10'd1, -16'sd32768, 16'sd32767);
    send_pixel(10'd2, 10'd1, 16'sd100, 16'sd100);
    apply_config(32'd2, 32'd2, 32'hF000_0000);
    send_pixel(10'd1, 10'd0, -16'sd32768, -16'sd32768);
    apply_config(32'd2, 32'd2, 32'h4000_0000);
    send_pixel(10'd0, 10'd1, 16'sd32767, 16'sd32767);
    // closed aperture keeps only the center
    apply_config(32'd3, 32'd0, 32'h8000_0000);
    send_pixel(10'd1, 10'd1, -16'sd32768, -16'sd32768);
    send_pixel(10'd0, 10'd1, 16'sd1234, -16'sd4321);
    send_pixel(10'd3, 10'd0, 16'sd77, 16'sd77);
    apply_config(32'd0, 32'd4194303, 32'h7FFF_FFFF);
    send_pixel(10'd0, 10'd0, 16'sd1, 16'sd1);
    apply_config(32'd2047, 32'd4194303, 32'h7FFF_FFFF);
    send_pixel(10'd1023, 10'd0, 16'sd32767, -16'sd1);
    send_pixel(10'd0, 10'd1023, -16'sd32768, 16'sd0);
    apply_config(32'd1, 32'd0, 32'h1000_0000);
    send_pixel(10'd0, 10'd0, 16'sd32767, 16'sd32767);
    send_pixel(10'd0, 10'd1, -16'sd5, 16'sd5);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: g = 1024;
        1: g = 1;
        5: g = 2047;
        default: g = $urandom_range(3) == 0 ? $urandom_range(2, 16) : $urandom_range(1024);
      endcase
      gm   = (g > mpap_pkg::MAX_GRID) ? mpap_pkg::MAX_GRID : g;
      span = (gm > 0) ? 2 * (gm - 1) * (gm - 1) : 0;
      aper = $urandom_range(span + span / 4 + 1);
      if (aper > 4194303) aper = 4194303;
      if (p == 0) aper = 4194303;
      if (p == 2) aper = 0;
      step = $urandom;
      if (p == 3) step = 32'h8000_0000;
      if (p == 6) step = 32'h7FFF_FFFF;
      apply_config(g, aper, step);
      case (p % 4)
        0: begin
          gap_pct <= 0; stall_pct <= 0;
        end
        1: begin
          gap_pct <= 51; stall_pct <= 0;
        end
        2: begin
          gap_pct <= 0; stall_pct <= 51;
        end
        default: begin
          gap_pct <= 13; stall_pct <= 13;
        end
      endcase
      if (p == 4) hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if (gm == 0 || $urandom_range(9) == 0) begin
          row = mpap_pkg::IDX_W'($urandom);
          col = mpap_pkg::IDX_W'($urandom);
        end else begin
          row = mpap_pkg::IDX_W'($urandom_range(gm - 1));
          col = mpap_pkg::IDX_W'($urandom_range(gm - 1));
        end
        send_pixel(row, col, rand_sample(), rand_sample());
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[mirror_phase_aperture_pixel] OK");
    else
      $display("[mirror_phase_aperture_pixel] ERROR");
    $finish;
  end

endmodule
